@@ hdl/hhp_pkg.sv @@
// hhp_pkg: shared widths, codes and fixed constants of the heading-hold PID drive.
// No dependencies; imported by hhp_mul, hhp_div and heading_hold_pid_drive.
package hhp_pkg;

    // serial arithmetic unit widths
    localparam int PW    = 50;                 // product / dividend width
    localparam int MB_W  = 20;                 // multiplier operand, one bit per cycle
    localparam int MB_CW = $clog2(MB_W + 1);
    localparam int DV_W  = 33;                 // divisor width
    localparam int DV_CW = $clog2(PW + 1);

    // direction codes
    localparam logic [2:0] DIR_STOP  = 3'd0;
    localparam logic [2:0] DIR_FWD   = 3'd1;
    localparam logic [2:0] DIR_BACK  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    // register indexes
    localparam logic [1:0] REG_KP  = 2'd0;
    localparam logic [1:0] REG_KI  = 2'd1;
    localparam logic [1:0] REG_KD  = 2'd2;
    localparam logic [1:0] REG_OFS = 2'd3;

    localparam logic [15:0] KP_RST = 16'd6144;
    localparam logic [15:0] KI_RST = 16'd41;
    localparam logic [15:0] KD_RST = 16'd2048;

    // fixed scaling
    localparam int INC_SHIFT  = 9;          // rate * ms * 512
    localparam int INC_ROUND  = 500;
    localparam int INC_DIV    = 1000;
    localparam int DEG_MUL    = 225;        // deg = yaw * 225 / (31 * 2^17)
    localparam int DEG_DIV    = 4063232;
    localparam int PCT_DIV    = 100;
    localparam int MS_SCALE   = 1000;
    localparam int D_SCALE    = 1000000;
    localparam int DEN_UNIT   = 4096000;
    localparam int ANG_HI     = 6490685;
    localparam int ANG_LO     = -6501171;
    localparam int DEG_FOLD   = 179;
    localparam int DEG_TURN   = 360;
    localparam int ERR_MS_MAX = 368280;     // 360 deg * 1023 ms

    localparam int INTEG_LIMIT_DEF = 100;
    localparam int DUTY_MAX_DEF    = 255;

endpackage

@@ hdl/hhp_mul.sv @@
// hhp_mul: shift-add multiplier, one multiplier bit per cycle.
// Depends on hhp_pkg (PW, MB_W, MB_CW).
module hhp_mul
    import hhp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PW-1:0]   i_a,
    input  logic [MB_W-1:0] i_b,
    output logic            o_done,
    output logic [PW-1:0]   o_prod
);

    logic             r_busy;
    logic [MB_CW-1:0] r_cnt;
    logic [PW-1:0]    r_acc;
    logic [PW-1:0]    r_a;
    logic [MB_W-1:0]  r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= MB_CW'(MB_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy && r_cnt != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_prod = r_acc;

endmodule

@@ hdl/hhp_div.sv @@
// hhp_div: restoring divider, one quotient bit per cycle.
// Depends on hhp_pkg (PW, DV_W, DV_CW).
module hhp_div
    import hhp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PW-1:0]   i_num,
    input  logic [DV_W-1:0] i_den,
    output logic            o_done,
    output logic [PW-1:0]   o_quo,
    output logic [DV_W-1:0] o_rem
);

    logic             r_busy;
    logic [DV_CW-1:0] r_cnt;
    logic [DV_W-1:0]  r_rem;
    logic [DV_W-1:0]  r_den;
    logic [PW-1:0]    r_quo;
    logic [DV_W:0]    w_t;
    logic [DV_W:0]    w_diff;
    logic             w_ge;

    assign w_t    = {r_rem, r_quo[PW-1]};
    assign w_ge   = w_t >= {1'b0, r_den};
    assign w_diff = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DV_CW'(PW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DV_W-1:0] : w_t[DV_W-1:0];
            r_quo <= {r_quo[PW-2:0], w_ge};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ hdl/heading_hold_pid_drive.sv @@
// heading_hold_pid_drive: top level, sequencer of the heading-hold PID drive.
// Depends on hhp_pkg, hhp_mul and hhp_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one beat per control tick carrying
//   the gyro rate, elapsed ms, direction code and speed in percent.
//   Output channel (o_out_valid / i_out_stall): one beat per tick with four
//   H-bridge duties, the folded heading in degrees and the PID correction.
//   Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 Kp, 1 Ki, 2 Kd, 3 rate offset); write only while the block is idle.
// Arithmetic:
//   All products and quotients run through one bit-serial multiplier and
//   one restoring divider. Stop, turn and hold ticks take three products
//   and three divisions; forward and backward ticks add nine products and
//   one division.
//   One tick is in work at a time; o_in_stall is high while it is.
// Reset: synchronous, active low; gains return to 1.5 / 0.01 / 0.5, offset,
//   angle, heading locks, integral and held duties clear to zero.
// Stall: a finished beat sits in the output register; the next tick may be
//   accepted and worked on, but its result waits until the register is free.
module heading_hold_pid_drive
    import hhp_pkg::*;
#(
    parameter int INTEG_LIMIT = INTEG_LIMIT_DEF,
    parameter int DUTY_MAX    = DUTY_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // input beat
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_yaw_rate,
    input  logic [9:0]         i_elapsed_ms,
    input  logic [2:0]         i_direction,
    input  logic [6:0]         i_speed_pct,
    // output beat
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_left_fwd_duty,
    output logic [7:0]         o_left_rev_duty,
    output logic [7:0]         o_right_fwd_duty,
    output logic [7:0]         o_right_rev_duty,
    output logic signed [8:0]  o_heading_deg,
    output logic signed [15:0] o_correction
);

    localparam int DUTY_W  = $clog2(DUTY_MAX + 1);
    localparam int INT_LIM = INTEG_LIMIT * MS_SCALE;
    localparam int INT_W   = $clog2(INT_LIM + ERR_MS_MAX + 1) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_INC_MUL, S_INC_DIV, S_DEG_MUL, S_DEG_DIV, S_PWM_MUL, S_PWM_DIV,
        S_LOCK, S_INT_MUL, S_P1, S_P2, S_P3, S_I1, S_I2, S_D1, S_D2, S_DEN,
        S_PID_DIV, S_MIX, S_OUT
    } t_state;

    t_state r_state;
    logic   r_wait;

    // config
    logic [15:0]        r_kp, r_ki, r_kd;
    logic signed [15:0] r_ofs;

    // captured tick
    logic               r_rate_neg;
    logic [16:0]        r_rate_mag;
    logic [9:0]         r_ms;
    logic [2:0]         r_dir;
    logic [6:0]         r_spd;

    // persistent state
    logic signed [23:0]      r_yaw;
    logic signed [8:0]       r_target;
    logic signed [9:0]       r_last;
    logic signed [INT_W-1:0] r_int;
    logic                    r_fwd, r_rev;
    logic [DUTY_W-1:0]       r_held [4];

    // per-tick working values
    logic signed [8:0]  r_deg;
    logic signed [9:0]  r_e;
    logic signed [10:0] r_de;
    logic [DUTY_W-1:0]  r_pwm;
    logic signed [PW:0] r_acc;
    logic [DV_W-1:0]    r_den;
    logic [PW-1:0]      r_q;
    logic               r_rnz;
    logic signed [15:0] r_corr;

    // output register
    logic               r_out_valid;
    logic [7:0]         r_o_lf, r_o_lr, r_o_rf, r_o_rr;
    logic signed [8:0]  r_o_deg;
    logic signed [15:0] r_o_corr;

    // arithmetic units
    logic            w_mul_go, w_div_go, w_mul_start, w_div_start;
    logic            w_mul_done, w_div_done;
    logic [PW-1:0]   w_mul_a, w_mul_prod, w_div_n, w_div_quo;
    logic [MB_W-1:0] w_mul_b;
    logic [DV_W-1:0] w_div_d, w_div_rem;

    hhp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    hhp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_n),
        .i_den   (w_div_d),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    // ---- combinational helpers ----
    logic signed [16:0]      w_rate;
    logic [23:0]             w_yaw_mag;
    logic [9:0]              w_m;
    logic [9:0]              w_e_abs;
    logic [10:0]             w_de_abs;
    logic [INT_W-1:0]        w_i_abs;
    logic signed [PW:0]      w_acc_abs;
    logic signed [PW:0]      w_prod_s;
    logic                    w_sgn;
    logic signed [PW:0]      w_term;

    assign w_rate    = 17'(i_yaw_rate) - 17'(r_ofs);
    assign w_yaw_mag = r_yaw[23] ? 24'(-r_yaw) : 24'(r_yaw);
    assign w_m       = (r_ms == '0) ? 10'd1 : r_ms;
    assign w_e_abs   = r_e[9] ? 10'(-r_e) : 10'(r_e);
    assign w_de_abs  = r_de[10] ? 11'(-r_de) : 11'(r_de);
    assign w_i_abs   = r_int[INT_W-1] ? INT_W'(-r_int) : INT_W'(r_int);
    assign w_acc_abs = r_acc[PW] ? -r_acc : r_acc;
    assign w_prod_s  = $signed({1'b0, w_mul_prod});
    assign w_term    = w_sgn ? -w_prod_s : w_prod_s;

    // operand selection per step
    always_comb begin
        w_mul_go = 1'b0;
        w_div_go = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_div_n  = '0;
        w_div_d  = '0;
        w_sgn    = 1'b0;
        unique case (r_state)
            S_INC_MUL: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(r_rate_mag);
                w_mul_b  = MB_W'(r_ms);
            end
            S_INC_DIV: begin
                w_div_go = 1'b1;
                w_div_n  = (w_mul_prod << INC_SHIFT) + PW'(INC_ROUND);
                w_div_d  = DV_W'(INC_DIV);
            end
            S_DEG_MUL: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(w_yaw_mag);
                w_mul_b  = MB_W'(DEG_MUL);
            end
            S_DEG_DIV: begin
                w_div_go = 1'b1;
                w_div_n  = w_mul_prod;
                w_div_d  = DV_W'(DEG_DIV);
            end
            S_PWM_MUL: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(DUTY_MAX);
                w_mul_b  = MB_W'(r_spd);
            end
            S_PWM_DIV: begin
                w_div_go = 1'b1;
                w_div_n  = w_mul_prod;
                w_div_d  = DV_W'(PCT_DIV);
            end
            S_INT_MUL: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(w_e_abs);
                w_mul_b  = MB_W'(r_ms);
            end
            S_P1: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(r_kp);
                w_mul_b  = MB_W'(w_e_abs);
            end
            S_P2: begin
                w_mul_go = 1'b1;
                w_mul_a  = w_mul_prod;
                w_mul_b  = MB_W'(MS_SCALE);
            end
            S_P3: begin
                w_mul_go = 1'b1;
                w_mul_a  = w_mul_prod;
                w_mul_b  = MB_W'(w_m);
                w_sgn    = r_e[9];
            end
            S_I1: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(r_ki);
                w_mul_b  = MB_W'(w_i_abs);
            end
            S_I2: begin
                w_mul_go = 1'b1;
                w_mul_a  = w_mul_prod;
                w_mul_b  = MB_W'(w_m);
                w_sgn    = r_int[INT_W-1];
            end
            S_D1: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(r_kd);
                w_mul_b  = MB_W'(w_de_abs);
            end
            S_D2: begin
                w_mul_go = 1'b1;
                w_mul_a  = w_mul_prod;
                w_mul_b  = MB_W'(D_SCALE);
                w_sgn    = r_de[10];
            end
            S_DEN: begin
                w_mul_go = 1'b1;
                w_mul_a  = PW'(DEN_UNIT);
                w_mul_b  = MB_W'(w_m);
            end
            S_PID_DIV: begin
                w_div_go = 1'b1;
                w_div_n  = w_acc_abs[PW-1:0];
                w_div_d  = r_den;
            end
            default: begin
            end
        endcase
    end

    assign w_mul_start = w_mul_go && !r_wait;
    assign w_div_start = w_div_go && !r_wait;

    // yaw update
    logic signed [27:0] w_inc_q, w_inc, w_sum;
    logic               w_out_range;
    assign w_inc_q     = $signed({2'b0, w_div_quo[25:0]});
    assign w_inc       = r_rate_neg ? -w_inc_q : w_inc_q;
    assign w_sum       = 28'(r_yaw) + w_inc;
    assign w_out_range = (w_sum > 28'(ANG_HI)) || (w_sum < 28'(ANG_LO));

    // degrees and fold
    logic signed [9:0] w_dq, w_degs, w_fold;
    assign w_dq   = $signed({1'b0, w_div_quo[8:0]});
    assign w_degs = r_yaw[23] ? -w_dq : w_dq;
    always_comb begin
        if (w_degs > 10'(DEG_FOLD)) begin
            w_fold = w_degs - 10'(DEG_TURN);
        end else if (w_degs < -10'(DEG_FOLD)) begin
            w_fold = w_degs + 10'(DEG_TURN);
        end else begin
            w_fold = w_degs;
        end
    end

    // heading lock
    logic              w_pid, w_lk;
    logic signed [8:0] w_targ;
    logic signed [9:0] w_lastv, w_e;
    logic signed [10:0] w_de;
    assign w_pid   = (r_dir == DIR_FWD) || (r_dir == DIR_BACK);
    assign w_lk    = (r_dir == DIR_FWD) ? r_fwd : r_rev;
    assign w_targ  = w_lk ? r_target : r_deg;
    assign w_lastv = w_lk ? r_last : '0;
    assign w_e     = 10'(w_targ) - 10'(r_deg);
    assign w_de    = 11'(w_e) - 11'(w_lastv);

    // integral clamp
    logic signed [INT_W-1:0] w_iprod, w_isum, w_iclamp;
    assign w_iprod = $signed(INT_W'(w_mul_prod));
    assign w_isum  = r_int + (r_e[9] ? -w_iprod : w_iprod);
    always_comb begin
        if (w_isum > INT_W'(INT_LIM)) begin
            w_iclamp = INT_W'(INT_LIM);
        end else if (w_isum < -INT_W'(INT_LIM)) begin
            w_iclamp = -INT_W'(INT_LIM);
        end else begin
            w_iclamp = w_isum;
        end
    end

    // mixing: floor of +-num/den from the magnitude quotient and remainder
    logic               w_neg;
    logic signed [29:0] w_qs, w_fl_pos, w_fl_neg, w_pwm_s, w_plus, w_minus, w_trunc;
    logic [DUTY_W-1:0]  w_dplus, w_dminus;
    logic signed [15:0] w_corr_sat;
    logic [DUTY_W-1:0]  w_d [4];

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [29:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > 30'(DUTY_MAX)) begin
            return DUTY_W'(DUTY_MAX);
        end
        return v[DUTY_W-1:0];
    endfunction

    assign w_neg    = r_acc[PW];
    assign w_qs     = $signed({3'b0, r_q[26:0]});
    assign w_fl_pos = w_neg ? (r_rnz ? -w_qs - 30'sd1 : -w_qs) : w_qs;
    assign w_fl_neg = w_neg ? w_qs : (r_rnz ? -w_qs - 30'sd1 : -w_qs);
    assign w_pwm_s  = $signed(30'(r_pwm));
    assign w_plus   = w_pwm_s + w_fl_pos;
    assign w_minus  = w_pwm_s + w_fl_neg;
    assign w_dplus  = clamp_duty(w_plus);
    assign w_dminus = clamp_duty(w_minus);
    assign w_trunc  = w_neg ? -w_qs : w_qs;

    always_comb begin
        if (w_trunc > 30'sd32767) begin
            w_corr_sat = 16'sh7FFF;
        end else if (w_trunc < -30'sd32768) begin
            w_corr_sat = 16'sh8000;
        end else begin
            w_corr_sat = w_trunc[15:0];
        end
    end

    always_comb begin
        unique case (r_dir)
            DIR_STOP: begin
                w_d[0] = '0; w_d[1] = '0; w_d[2] = '0; w_d[3] = '0;
            end
            DIR_FWD: begin
                w_d[0] = w_dminus; w_d[1] = '0; w_d[2] = w_dplus; w_d[3] = '0;
            end
            DIR_BACK: begin
                w_d[0] = '0; w_d[1] = w_dplus; w_d[2] = '0; w_d[3] = w_dminus;
            end
            DIR_LEFT: begin
                w_d[0] = r_pwm; w_d[1] = '0; w_d[2] = '0; w_d[3] = r_pwm;
            end
            DIR_RIGHT: begin
                w_d[0] = '0; w_d[1] = r_pwm; w_d[2] = r_pwm; w_d[3] = '0;
            end
            default: begin
                // unknown code: keep driving what was driven last
                w_d[0] = r_held[0]; w_d[1] = r_held[1];
                w_d[2] = r_held[2]; w_d[3] = r_held[3];
            end
        endcase
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_kp        <= KP_RST;
            r_ki        <= KI_RST;
            r_kd        <= KD_RST;
            r_ofs       <= '0;
            r_yaw       <= '0;
            r_target    <= '0;
            r_last      <= '0;
            r_int       <= '0;
            r_fwd       <= 1'b0;
            r_rev       <= 1'b0;
            r_held[0]   <= '0;
            r_held[1]   <= '0;
            r_held[2]   <= '0;
            r_held[3]   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KP:  r_kp  <= i_cfg_data;
                    REG_KI:  r_ki  <= i_cfg_data;
                    REG_KD:  r_kd  <= i_cfg_data;
                    REG_OFS: r_ofs <= $signed(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            // S_OUT reloads the register itself when the beat leaves
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rate_neg <= w_rate[16];
                        r_rate_mag <= w_rate[16] ? 17'(-w_rate) : 17'(w_rate);
                        r_ms       <= i_elapsed_ms;
                        r_dir      <= i_direction;
                        r_spd      <= i_speed_pct;
                        r_state    <= S_INC_MUL;
                    end
                end
                S_INC_MUL, S_DEG_MUL, S_PWM_MUL, S_P1, S_P2, S_I1, S_D1: begin
                    if (w_mul_done) begin
                        r_wait <= 1'b0;
                        unique case (r_state)
                            S_INC_MUL: r_state <= S_INC_DIV;
                            S_DEG_MUL: r_state <= S_DEG_DIV;
                            S_PWM_MUL: r_state <= S_PWM_DIV;
                            S_P1:      r_state <= S_P2;
                            S_P2:      r_state <= S_P3;
                            S_I1:      r_state <= S_I2;
                            default:   r_state <= S_D2;
                        endcase
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_INC_DIV: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_yaw   <= w_out_range ? '0 : w_sum[23:0];
                        r_state <= S_DEG_MUL;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_DEG_DIV: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_deg   <= w_fold[8:0];
                        r_state <= S_PWM_MUL;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_PWM_DIV: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_pwm   <= (w_div_quo > PW'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                                : w_div_quo[DUTY_W-1:0];
                        r_state <= S_LOCK;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_LOCK: begin
                    // first tick of a mode locks the heading and restarts the PID
                    if (w_pid) begin
                        r_target <= w_targ;
                        r_e      <= w_e;
                        r_de     <= w_de;
                        r_last   <= w_e;
                        if (!w_lk) begin
                            r_int <= '0;
                        end
                    end
                    r_fwd   <= (r_dir == DIR_FWD);
                    r_rev   <= (r_dir == DIR_BACK);
                    r_state <= w_pid ? S_INT_MUL : S_MIX;
                end
                S_INT_MUL: begin
                    if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_int   <= w_iclamp;
                        r_state <= S_P1;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_P3: begin
                    if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_acc   <= w_term;
                        r_state <= S_I1;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_I2: begin
                    if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_acc   <= r_acc + w_term;
                        r_state <= S_D1;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_D2: begin
                    if (w_mul_done) begin
                        r_wait <= 1'b0;
                        if (r_ms != '0) begin
                            r_acc <= r_acc + w_term;
                        end
                        r_state <= S_DEN;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_DEN: begin
                    if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_den   <= w_mul_prod[DV_W-1:0];
                        r_state <= S_PID_DIV;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_PID_DIV: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_q     <= w_div_quo;
                        r_rnz   <= (w_div_rem != '0);
                        r_state <= S_MIX;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_MIX: begin
                    r_held[0] <= w_d[0];
                    r_held[1] <= w_d[1];
                    r_held[2] <= w_d[2];
                    r_held[3] <= w_d[3];
                    r_corr    <= w_pid ? w_corr_sat : '0;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_lf      <= 8'(r_held[0]);
                        r_o_lr      <= 8'(r_held[1]);
                        r_o_rf      <= 8'(r_held[2]);
                        r_o_rr      <= 8'(r_held[3]);
                        r_o_deg     <= r_deg;
                        r_o_corr    <= r_corr;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_left_fwd_duty  = r_o_lf;
    assign o_left_rev_duty  = r_o_lr;
    assign o_right_fwd_duty = r_o_rf;
    assign o_right_rev_duty = r_o_rr;
    assign o_heading_deg    = r_o_deg;
    assign o_correction     = r_o_corr;

    // ---- checks ----
    a_lock_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fwd && r_rev))
        else $error("forward and backward locks both set");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_yaw <= 24'(ANG_HI)) && (r_yaw >= 24'(ANG_LO)))
        else $error("yaw angle outside wrap window");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_INC_MUL))
        else $error("accepted beat did not start the sequence");

    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("multiplier and divider finished together");

endmodule
